/* rtl/core/evr_pkg.sv */
// Shared types and constants for the equirectangular view remap coordinate unit.
`default_nettype none
package evr_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_ROT_ROW0   = 3'd0;
    localparam logic [2:0] REG_ROT_ROW1   = 3'd1;
    localparam logic [2:0] REG_ROT_ROW2   = 3'd2;
    localparam logic [2:0] REG_INV_FOCAL  = 3'd3;
    localparam logic [2:0] REG_OFFSET_X   = 3'd4;
    localparam logic [2:0] REG_OFFSET_Y   = 3'd5;
    localparam logic [2:0] REG_SRC_WIDTH  = 3'd6;
    localparam logic [2:0] REG_SRC_HEIGHT = 3'd7;

    localparam int CW = 33;   // CORDIC x/y width
    localparam int AW = 34;   // angle width, Q.30 radians

    localparam logic signed [AW-1:0] Q30_HALF_PI  = 34'sd1686629713;
    localparam logic signed [31:0]   INV_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [31:0]   INV_2PI_Q32  = 32'sd683565276;
    localparam logic signed [31:0]   INV_PI_Q32   = 32'sd1367130551;
    localparam int NORM_BITS = 29;
    localparam int MAX_ITER  = 24;

    localparam logic [31:0] ATAN_TAB [MAX_ITER] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
        32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
        32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
        32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
    };

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
    } cordic_t;

endpackage
`default_nettype wire

/* rtl/core/evr_cordic_step.sv */
// One registered vectoring CORDIC iteration.
`default_nettype none
module evr_cordic_step
    import evr_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  wire logic    clk,
    input  wire logic    en,
    input  wire cordic_t d,
    output cordic_t      q
);

    localparam logic signed [AW-1:0] ATAN_I = AW'(signed'({1'b0, ATAN_TAB[IDX]}));

    cordic_t q_reg;
    cordic_t q_next;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    always_comb
    begin
        dx = d.y >>> IDX;
        dy = d.x >>> IDX;
        if (!d.y[CW-1])
        begin
            q_next.x   = d.x + dx;
            q_next.y   = d.y - dy;
            q_next.ang = d.ang + ATAN_I;
        end
        else
        begin
            q_next.x   = d.x - dx;
            q_next.y   = d.y + dy;
            q_next.ang = d.ang - ATAN_I;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule
`default_nettype wire

/* rtl/core/equirect_view_remap_coords_unit.sv */
// Top level: pixel to equirectangular source coordinate pipeline.
// N = min(CORDIC_ITERATIONS, 24) is the number of CORDIC iterations;
// each CORDIC iteration is one register stage.
// Throughput: one coordinate pair per cycle; empty stages close up under output stall.
// Reset: valid bits clear and configuration registers return to their defaults;
// payload registers are not reset.
`default_nettype none
module equirect_view_remap_coords_unit
    import evr_pkg::*;
#(
    parameter int MAX_OUTPUT_DIM    = 4096,
    parameter int MAX_SOURCE_DIM    = 16384,
    parameter int CORDIC_ITERATIONS = 18
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pix_x[11:0], pix_y[23:12]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // src_x[21:0], src_y[43:22], zero [47:44]
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [53:0] cfg_data
);

    localparam int N   = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;
    localparam int S_LON0 = 6;
    localparam int S_GAIN = 7 + N;
    localparam int S_C1   = 8 + 2 * N;
    localparam int S_C2   = 9 + 2 * N;
    localparam int S_OUT  = 10 + 2 * N;
    localparam int NST    = 11 + 2 * N;
    localparam int RW = 38;
    localparam int PW = 56;
    localparam int VW = 58;
    localparam int NW = 30;

    // configuration
    logic [53:0] rot0_reg, rot1_reg, rot2_reg;
    logic [23:0] inv_focal_reg;
    logic [28:0] offset_x_reg, offset_y_reg;
    logic [13:0] width_span_reg, height_span_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot0_reg        <= 54'd65536;
            rot1_reg        <= 54'd17179869184;
            rot2_reg        <= 54'd4503599627370496;
            inv_focal_reg   <= 24'd16384;
            offset_x_reg    <= '0;
            offset_y_reg    <= '0;
            width_span_reg  <= 14'd4095;
            height_span_reg <= 14'd2047;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT_ROW0:   rot0_reg        <= cfg_data;
                REG_ROT_ROW1:   rot1_reg        <= cfg_data;
                REG_ROT_ROW2:   rot2_reg        <= cfg_data;
                REG_INV_FOCAL:  inv_focal_reg   <= cfg_data[23:0];
                REG_OFFSET_X:   offset_x_reg    <= cfg_data[28:0];
                REG_OFFSET_Y:   offset_y_reg    <= cfg_data[28:0];
                REG_SRC_WIDTH:  width_span_reg  <= cfg_data[13:0];
                REG_SRC_HEIGHT: height_span_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    function automatic logic [13:0] clamp_span(input logic [13:0] s);
        if (int'(s) > MAX_SOURCE_DIM - 1)
            return 14'(MAX_SOURCE_DIM - 1);
        return s;
    endfunction

    function automatic logic [11:0] clamp_pix(input logic [11:0] p);
        if (int'(p) > MAX_OUTPUT_DIM - 1)
            return 12'(MAX_OUTPUT_DIM - 1);
        return p;
    endfunction

    logic signed [17:0] m [3][3];
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            m[0][k] = rot0_reg[18*k +: 18];
            m[1][k] = rot1_reg[18*k +: 18];
            m[2][k] = rot2_reg[18*k +: 18];
        end
    end

    // valid bits and stall chain: a stage loads when empty or when the next one loads
    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !valid_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (en[0])
                valid_reg[0] <= s_tvalid;
            for (int k = 1; k < NST; k++)
                if (en[k])
                    valid_reg[k] <= valid_reg[k-1];
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[NST-1];

    // stage 0: input
    logic [11:0] px_reg, py_reg;
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            px_reg <= clamp_pix(s_tdata[11:0]);
            py_reg <= clamp_pix(s_tdata[23:12]);
        end
    end

    // stage 1: camera ray
    logic [35:0] pfx, pfy;
    logic signed [RW-1:0] rx_reg, ry_reg;
    always_comb
    begin
        pfx = px_reg * inv_focal_reg;
        pfy = py_reg * inv_focal_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rx_reg <= $signed({2'b00, pfx}) + $signed({{5{offset_x_reg[28]}}, offset_x_reg, 4'b0});
            ry_reg <= $signed({2'b00, pfy}) + $signed({{5{offset_y_reg[28]}}, offset_y_reg, 4'b0});
        end
    end

    // stage 2: matrix products
    logic signed [PW-1:0] p0_reg [3];
    logic signed [PW-1:0] p1_reg [3];
    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            for (int r = 0; r < 3; r++)
            begin
                p0_reg[r] <= m[r][0] * rx_reg;
                p1_reg[r] <= m[r][1] * ry_reg;
            end
        end
    end

    // stage 3: rotated vector, Q.40
    logic signed [VW-1:0] v_reg [3];
    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            for (int r = 0; r < 3; r++)
                v_reg[r] <= VW'(p0_reg[r]) + VW'(p1_reg[r]) + (VW'(m[r][2]) <<< 24);
        end
    end

    // stage 4: largest magnitude and its bit length
    logic [VW-1:0] mag_abs [3];
    logic [VW-1:0] mmax;
    logic [5:0]    len_next;
    logic signed [VW-1:0] v4_reg [3];
    logic [5:0]    len_reg;
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            mag_abs[r] = v_reg[r][VW-1] ? VW'(-v_reg[r]) : VW'(v_reg[r]);
        mmax = mag_abs[0];
        if (mag_abs[1] > mmax)
            mmax = mag_abs[1];
        if (mag_abs[2] > mmax)
            mmax = mag_abs[2];
        len_next = '0;
        for (int i = 0; i < VW; i++)
            if (mmax[i])
                len_next = 6'(i + 1);
    end
    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            v4_reg  <= v_reg;
            len_reg <= len_next;
        end
    end

    // stage 5: normalize so the largest magnitude lies in [2^28, 2^29)
    logic signed [VW-1:0] sh [3];
    logic signed [NW-1:0] vn_reg [3];
    logic mz5_reg;
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (int'(len_reg) > NORM_BITS)
                sh[r] = v4_reg[r] >>> (int'(len_reg) - NORM_BITS);
            else
                sh[r] = v4_reg[r] <<< (NORM_BITS - int'(len_reg));
        end
    end
    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int r = 0; r < 3; r++)
                vn_reg[r] <= sh[r][NW-1:0];
            mz5_reg <= (len_reg == '0);
        end
    end

    // stage 6: fold a negative z into the right half plane
    cordic_t lon_c [N+1];
    logic signed [NW-1:0] lon_v1_reg [N+1];
    logic                 lon_zero_reg [N+1];
    logic                 lon_mz_reg [N+1];
    cordic_t lon_init_reg;
    cordic_t lon_init_next;
    logic signed [CW-1:0] xe, ye;
    always_comb
    begin
        xe = CW'(vn_reg[2]);
        ye = CW'(vn_reg[0]);
        lon_init_next.x   = xe;
        lon_init_next.y   = ye;
        lon_init_next.ang = '0;
        if (xe[CW-1])
        begin
            if (!ye[CW-1])
            begin
                lon_init_next.ang = Q30_HALF_PI;
                lon_init_next.x   = ye;
                lon_init_next.y   = -xe;
            end
            else
            begin
                lon_init_next.ang = -Q30_HALF_PI;
                lon_init_next.x   = -ye;
                lon_init_next.y   = xe;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (en[S_LON0])
        begin
            lon_init_reg    <= lon_init_next;
            lon_v1_reg[0]   <= vn_reg[1];
            lon_mz_reg[0]   <= mz5_reg;
            lon_zero_reg[0] <= mz5_reg || (vn_reg[0] == '0 && vn_reg[2] == '0);
        end
    end
    assign lon_c[0] = lon_init_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_lon
        evr_cordic_step #(.IDX(i)) u_step (
            .clk (clk),
            .en  (en[S_LON0 + 1 + i]),
            .d   (lon_c[i]),
            .q   (lon_c[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en[S_LON0 + 1 + i])
            begin
                lon_v1_reg[i+1]   <= lon_v1_reg[i];
                lon_zero_reg[i+1] <= lon_zero_reg[i];
                lon_mz_reg[i+1]   <= lon_mz_reg[i];
            end
        end
    end

    // gain correction of the horizontal magnitude
    logic signed [63:0]   gain_reg;
    logic signed [AW-1:0] lon_reg;
    logic signed [NW-1:0] g_v1_reg;
    logic                 g_mz_reg;
    always_ff @(posedge clk)
    begin
        if (en[S_GAIN])
        begin
            gain_reg <= lon_c[N].x * INV_GAIN_Q30;
            lon_reg  <= lon_zero_reg[N] ? '0 : lon_c[N].ang;
            g_v1_reg <= lon_v1_reg[N];
            g_mz_reg <= lon_mz_reg[N];
        end
    end

    cordic_t lat_c [N+1];
    logic signed [AW-1:0] lat_lon_reg [N+1];
    logic                 lat_mz_reg [N+1];
    always_comb
    begin
        lat_c[0].x     = gain_reg[62:30];
        lat_c[0].y     = CW'(g_v1_reg);
        lat_c[0].ang   = '0;
        lat_lon_reg[0] = lon_reg;
        lat_mz_reg[0]  = g_mz_reg;
    end

    for (genvar i = 0; i < N; i++)
    begin : g_lat
        evr_cordic_step #(.IDX(i)) u_step (
            .clk (clk),
            .en  (en[S_GAIN + 1 + i]),
            .d   (lat_c[i]),
            .q   (lat_c[i+1])
        );
        always_ff @(posedge clk)
        begin
            if (en[S_GAIN + 1 + i])
            begin
                lat_lon_reg[i+1] <= lat_lon_reg[i];
                lat_mz_reg[i+1]  <= lat_mz_reg[i];
            end
        end
    end

    // angle to fraction of the span
    logic signed [65:0] plon_reg, plat_reg;
    logic signed [AW-1:0] lat_final;
    assign lat_final = lat_mz_reg[N] ? '0 : lat_c[N].ang;
    always_ff @(posedge clk)
    begin
        if (en[S_C1])
        begin
            plon_reg <= lat_lon_reg[N] * INV_2PI_Q32;
            plat_reg <= lat_final * INV_PI_Q32;
        end
    end

    logic signed [34:0] fx, fy;
    logic [33:0] fxu, fyu;
    logic [47:0] qx_reg, qy_reg;
    always_comb
    begin
        fx  = 35'($signed(plon_reg[65:32])) + 35'sd536870912;
        fy  = 35'($signed(plat_reg[65:32])) + 35'sd536870912;
        fxu = fx[34] ? '0 : fx[33:0];
        fyu = fy[34] ? '0 : fy[33:0];
    end
    always_ff @(posedge clk)
    begin
        if (en[S_C2])
        begin
            qx_reg <= fxu * clamp_span(width_span_reg);
            qy_reg <= fyu * clamp_span(height_span_reg);
        end
    end

    // round half up to Q.8 and saturate to the span
    logic [47:0] tx, ty;
    logic [25:0] cx, cy;
    logic [25:0] limx, limy;
    logic [21:0] src_x_reg, src_y_reg;
    always_comb
    begin
        tx   = qx_reg + 48'd2097152;
        ty   = qy_reg + 48'd2097152;
        limx = {4'b0, clamp_span(width_span_reg), 8'b0};
        limy = {4'b0, clamp_span(height_span_reg), 8'b0};
        cx   = (tx[47:22] > limx) ? limx : tx[47:22];
        cy   = (ty[47:22] > limy) ? limy : ty[47:22];
    end
    always_ff @(posedge clk)
    begin
        if (en[S_OUT])
        begin
            src_x_reg <= cx[21:0];
            src_y_reg <= cy[21:0];
        end
    end

    assign m_tdata = {4'b0, src_y_reg, src_x_reg};

endmodule
`default_nettype wire

/* rtl/core/evr_checker.sv */
// Port-level checks for the remap coordinate unit, bound to the top level.
`default_nettype none
module evr_port_checks
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output transfer dropped or changed under stall");

    // pipeline empty at its end never refuses input
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input refused with empty output stage");

    // a draining output frees every stage
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input refused while output drains");

    // nothing comes out during reset
    assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("output valid during reset");

    // padding bits stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[47:44] == 4'b0)
        else $error("nonzero padding in output data");

endmodule

bind equirect_view_remap_coords_unit evr_port_checks u_evr_checker (.*);
`default_nettype wire
